FILE: rtl/pressure_sensor_conditioner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure sensor conditioner
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_CONDITIONER_ASSERT_SVH
`define PRESSURE_SENSOR_CONDITIONER_ASSERT_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pressure_sensor_conditioner: assertion failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pressure_sensor_conditioner: assertion failed");

`endif

FILE: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure sensor conditioner.
// ----------------------------------------------------------------------------
package psc_pkg;

  // ring depth, must be a power of two (2..64)
  localparam int unsigned WINDOW   = 8;
  localparam int unsigned WinBits  = $clog2(WINDOW);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // divider: 20-bit dividend (diff * 10), 12-bit divisor (span / 30)
  localparam int unsigned DivNumW  = 20;
  localparam int unsigned DivDenW  = 12;
  localparam int unsigned DivCntW  = $clog2(DivNumW);

  localparam int unsigned CalW     = DivNumW + 2;
  localparam int unsigned RsumW    = 16 + WinBits;
  localparam int unsigned PsumW    = 16 + WinBits;

  localparam int unsigned CalSpan    = 30;   // cmH2O per calibration segment
  localparam int unsigned CalOffset  = 300;  // 30 cmH2O in 0.1 units
  localparam int unsigned AlarmScale = 10;   // 0.1 cmH2O -> cmH2O
  localparam int unsigned HoldMax    = 16;

  // span / 30 as (span * CalRecip) >> CalRecipShift, exact for any 16-bit span
  localparam int unsigned CalRecip      = 34953;
  localparam int unsigned CalRecipShift = 20;

  localparam logic signed [15:0] PresMax = 16'sh7fff;
  localparam logic signed [15:0] PresMin = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_POINT      = 3'd0,
    CFG_THIRTY_POINT    = 3'd1,
    CFG_SIXTY_POINT     = 3'd2,
    CFG_ALARM_LIMIT     = 3'd3,
    CFG_INSP_TIME_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] sample;
    logic        mode_active;
    logic        trigger_view;
    logic        inspiration_flow;
    logic [15:0] insp_time_count;
  } psc_in_t;

  typedef struct packed {
    logic        [15:0] raw_average;
    logic signed [15:0] pressure_now;
    logic signed [15:0] pressure_average;
    logic        [14:0] second_peak;
    logic               high_alarm;
    logic               cal_error;
  } psc_out_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } psc_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quot;
  } psc_div_rsp_t;

endpackage

FILE: rtl/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  psc_div_req_t req_i,
  output psc_div_rsp_t rsp_o
);

  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivDenW:0]   shifted;
  logic               ge;
  logic [DivDenW-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DivNumW-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? DivDenW'(shifted - {1'b0, den_q}) : shifted[DivDenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= req_i.dividend;
      den_q  <= req_i.divisor;
      rem_q  <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivNumW-2:0], ge};
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: rtl/pressure_sensor_conditioner.sv
// ----------------------------------------------------------------------------
// pressure_sensor_conditioner
// Moving average, two-segment calibration, window second peak and pressure alarm.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel (in_valid_i / in_ready_o / in_data_i): one raw sample word
//       with the ventilation phase bits and the inspiration time count.
//   out channel (out_valid_o / out_ready_i / out_data_o): one result word
//       per input word: raw window mean, calibrated pressure, pressure
//       window average, second peak, alarm flag and calibration error.
//   cfg port (cfg_we_i / cfg_idx_i / cfg_data_i): calibration points and
//   alarm limits, to be written by the user only while the block is idle;
//   the block itself does not enforce this.
// Flow: setup, then the 20-step division diff * 10 / (span / 30) on the
//   divider, with span / 30 taken by a reciprocal multiply, then a scan
//   of the rings; the division is skipped when the segment span is short.
// Input: in_ready_o is high only between words; no new word is taken
//   until the last one's result is in the output register.
// Stall: a finished result sits in the output register; the next word is
//   taken and worked on meanwhile, and it waits at its end until the
//   output register is free.
// Reset: rings, ring position, alarm state and registers all clear to zero.
// ----------------------------------------------------------------------------
`include "pressure_sensor_conditioner_assert.svh"

module pressure_sensor_conditioner import psc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psc_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_SPAN,
    ST_DIV_CAL,
    ST_CALC,
    ST_SCAN,
    ST_DONE
  } state_e;

  // configuration registers
  logic [15:0] cfg_zero_q, cfg_thirty_q, cfg_sixty_q, cfg_insp_q;
  logic [11:0] cfg_alarm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_zero_q   <= '0;
      cfg_thirty_q <= '0;
      cfg_sixty_q  <= '0;
      cfg_alarm_q  <= '0;
      cfg_insp_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ZERO_POINT:      cfg_zero_q   <= cfg_data_i;
        CFG_THIRTY_POINT:    cfg_thirty_q <= cfg_data_i;
        CFG_SIXTY_POINT:     cfg_sixty_q  <= cfg_data_i;
        CFG_ALARM_LIMIT:     cfg_alarm_q  <= cfg_data_i[11:0];
        CFG_INSP_TIME_LIMIT: cfg_insp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  psc_in_t                  in_q;
  logic [15:0]              raw_ring_q  [WINDOW];
  logic signed [15:0]       pres_ring_q [WINDOW];
  logic [WinBits-1:0]       pos_q;
  logic [WinBits-1:0]       idx_q;
  logic                     alarm_q;
  logic [4:0]               alarm_cnt_q;
  logic [DivNumW-1:0]       diff10_q;
  logic [15:0]              span_q;
  logic                     above_q, below_q, err_q;
  logic signed [15:0]       p_q;
  logic [RsumW-1:0]         rsum_q;
  logic signed [PsumW-1:0]  psum_q;
  logic signed [15:0]       mx_q, sec_q;
  logic                     out_valid_q;
  psc_out_t                 out_data_q;

  psc_div_req_t div_req;
  psc_div_rsp_t div_rsp;

  psc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic in_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // segment selection for the latched sample
  logic               seg_above, seg_mid, span_err;
  logic [15:0]        seg_lo, seg_hi, seg_diff;
  logic signed [16:0] span;
  logic [DivNumW-1:0] diff10;

  always_comb begin
    seg_above = in_q.sample >= cfg_thirty_q;
    seg_mid   = in_q.sample >= cfg_zero_q;
    seg_lo    = seg_above ? cfg_thirty_q : cfg_zero_q;
    seg_hi    = seg_above ? cfg_sixty_q : cfg_thirty_q;
    span      = $signed({1'b0, seg_hi}) - $signed({1'b0, seg_lo});
    span_err  = span < $signed(17'(CalSpan));
    priority if (seg_above) begin
      seg_diff = in_q.sample - cfg_thirty_q;
    end else if (seg_mid) begin
      seg_diff = in_q.sample - cfg_zero_q;
    end else begin
      seg_diff = cfg_zero_q - in_q.sample;
    end
    diff10 = DivNumW'({seg_diff, 3'b000}) + DivNumW'({seg_diff, 1'b0});
  end

  // span / 30 by reciprocal multiply, then diff * 10 / that on the divider
  logic [31:0] span_prod;

  always_comb begin
    span_prod        = 32'(span_q) * 32'(CalRecip);
    div_req.start    = (state_q == ST_DIV_SPAN);
    div_req.dividend = diff10_q;
    div_req.divisor  = span_prod[CalRecipShift +: DivDenW];
  end

  // calibrated value with saturation
  logic signed [CalW-1:0] qext, cal_val;
  logic signed [15:0]     p_d;

  always_comb begin
    qext    = $signed({2'b00, div_rsp.quot});
    cal_val = below_q ? -qext
                      : qext + (above_q ? $signed(CalW'(CalOffset)) : $signed(CalW'(0)));
    priority if (err_q) begin
      p_d = below_q ? PresMin : PresMax;
    end else if (cal_val > CalW'(PresMax)) begin
      p_d = PresMax;
    end else if (cal_val < CalW'(PresMin)) begin
      p_d = PresMin;
    end else begin
      p_d = cal_val[15:0];
    end
  end

  // one ring slot per scan cycle
  logic [15:0]        scan_raw;
  logic signed [15:0] scan_p;
  logic signed [16:0] scan_adj, scan_div;

  always_comb begin
    scan_raw = raw_ring_q[idx_q];
    scan_p   = pres_ring_q[idx_q];
    // truncate toward zero: bias negatives before the shift
    scan_adj = {scan_p[15], scan_p} + (scan_p[15] ? $signed(17'(WINDOW - 1)) : 17'sd0);
    scan_div = scan_adj >>> WinBits;
  end

  // alarm update
  logic        alarm_d;
  logic [4:0]  alarm_cnt_d;
  logic [16:0] lim10;
  logic        alarm_set;

  always_comb begin
    lim10       = 17'(cfg_alarm_q) * 17'(AlarmScale) + 17'(AlarmScale - 1);
    alarm_set   = $signed({p_q[15], p_q}) > $signed(lim10);
    alarm_d     = alarm_q;
    alarm_cnt_d = alarm_cnt_q;
    if (in_q.mode_active) begin
      if (alarm_set) alarm_d = 1'b1;
      if (in_q.insp_time_count >= cfg_insp_q) alarm_d = 1'b0;
      if (in_q.trigger_view && in_q.inspiration_flow) alarm_d = 1'b0;
      alarm_cnt_d = alarm_d ? alarm_cnt_q + 1'b1 : 5'd0;
      if (alarm_cnt_d > 5'(HoldMax)) begin
        alarm_cnt_d = 5'd0;
        alarm_d     = 1'b0;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_q        <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        raw_ring_q[i]  <= '0;
        pres_ring_q[i] <= '0;
      end
      pos_q       <= '0;
      idx_q       <= '0;
      alarm_q     <= 1'b0;
      alarm_cnt_q <= '0;
      diff10_q    <= '0;
      span_q      <= '0;
      above_q     <= 1'b0;
      below_q     <= 1'b0;
      err_q       <= 1'b0;
      p_q         <= '0;
      rsum_q      <= '0;
      psum_q      <= '0;
      mx_q        <= '0;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // a result written in ST_DONE replaces the one taken this cycle
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            in_q              <= in_data_i;
            raw_ring_q[pos_q] <= in_data_i.sample;
            state_q           <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          diff10_q <= diff10;
          span_q   <= span[15:0];
          above_q  <= seg_above;
          below_q  <= !seg_above && !seg_mid;
          err_q    <= span_err;
          state_q  <= span_err ? ST_CALC : ST_DIV_SPAN;
        end
        ST_DIV_SPAN: begin
          state_q <= ST_DIV_CAL;
        end
        ST_DIV_CAL: begin
          if (div_rsp.done) state_q <= ST_CALC;
        end
        ST_CALC: begin
          p_q                <= p_d;
          pres_ring_q[pos_q] <= p_d;
          idx_q              <= '0;
          rsum_q             <= '0;
          psum_q             <= '0;
          mx_q               <= '0;
          sec_q              <= '0;
          state_q            <= ST_SCAN;
        end
        ST_SCAN: begin
          rsum_q <= rsum_q + RsumW'(scan_raw);
          psum_q <= psum_q + PsumW'(scan_div);
          // running top two; ties go to the second slot
          if (scan_p > mx_q) begin
            mx_q  <= scan_p;
            sec_q <= mx_q;
          end else if (scan_p > sec_q) begin
            sec_q <= scan_p;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == WinBits'(WINDOW - 1)) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q                 <= 1'b1;
            out_data_q.raw_average      <= rsum_q[WinBits +: 16];
            out_data_q.pressure_now     <= p_q;
            if (psum_q > PsumW'(PresMax)) begin
              out_data_q.pressure_average <= PresMax;
            end else if (psum_q < PsumW'(PresMin)) begin
              out_data_q.pressure_average <= PresMin;
            end else begin
              out_data_q.pressure_average <= psum_q[15:0];
            end
            out_data_q.second_peak      <= sec_q[14:0];
            out_data_q.high_alarm       <= alarm_d;
            out_data_q.cal_error        <= err_q;
            alarm_q                     <= alarm_d;
            alarm_cnt_q                 <= alarm_cnt_d;
            pos_q   <= (pos_q == WinBits'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  logic err_on_rail;
  assign err_on_rail = (out_data_o.pressure_now == PresMax) ||
                       (out_data_o.pressure_now == PresMin);

  // divider is never restarted mid-division
  `PSC_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy)
  // a short span always shows as a rail value
  `PSC_ASSERT_IMP(a_err_rail, out_valid_o && out_data_o.cal_error, err_on_rail)
  // hold count never passes its limit
  `PSC_ASSERT_IMP(a_hold_bound, 1'b1, alarm_cnt_q <= 5'(HoldMax))
  // a word taken always goes into segment setup
  `PSC_ASSERT_NEXT(a_fire_setup, in_fire, state_q == ST_SETUP)

endmodule

FILE: tb/psc_checker.sv
// ============================================================================
// psc_checker
// Watches the word channels and the register port of the pressure sensor
// conditioner, predicts every result word from its own copy of the rings,
// calibration and alarm state, and compares field by field in order.
// ============================================================================
module psc_checker import psc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  psc_in_t         in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  psc_out_t        out_data_i,
  input  logic            cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              results_o,
  output int              alarms_o,
  output int              cal_errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] zero_pt, thirty_pt, sixty_pt, insp_limit;
  logic [11:0] alarm_lim;

  // block state
  logic [15:0]        raw_ring [WINDOW];
  int                 pres_ring [WINDOW];
  logic [WinBits-1:0] slot;
  logic               alarm_on;
  logic [4:0]         hold_cnt;

  psc_out_t expected_q [$];
  psc_out_t want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] psc mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic int sat16(input longint v);
    int r;
    if (v > 32767) r = 32767;
    else if (v < -32768) r = -32768;
    else r = int'(v);
    return r;
  endfunction

  // two-segment calibration to 0.1 cmH2O
  function automatic int calibrate(input logic [15:0] s, output logic err);
    longint sl, lo, hi, span, diff, q;
    int     offs;
    logic   below;
    sl    = s;
    offs  = 0;
    below = 1'b0;
    if (s >= thirty_pt) begin
      lo   = thirty_pt;
      hi   = sixty_pt;
      diff = sl - lo;
      offs = CalOffset;
    end else if (s >= zero_pt) begin
      lo   = zero_pt;
      hi   = thirty_pt;
      diff = sl - lo;
    end else begin
      lo    = zero_pt;
      hi    = thirty_pt;
      diff  = lo - sl;
      below = 1'b1;
    end
    span = hi - lo;
    if (span < longint'(CalSpan)) begin
      err = 1'b1;
      return below ? -32768 : 32767;
    end
    err = 1'b0;
    q = (diff * 10) / (span / longint'(CalSpan));
    if (below) q = -q;
    return sat16(q + offs);
  endfunction

  // one input word: update rings and alarm, return the result word
  function automatic psc_out_t condition_word(input psc_in_t w);
    psc_out_t    r;
    longint      rsum, psum;
    int          p, peak, second, lim;
    int unsigned peak_slot;
    logic        err;
    rsum = 0;
    psum = 0;
    raw_ring[slot] = w.sample;
    for (int i = 0; i < WINDOW; i++) rsum += raw_ring[i];
    p = calibrate(w.sample, err);
    pres_ring[slot] = p;
    for (int i = 0; i < WINDOW; i++) psum += pres_ring[i] / int'(WINDOW);
    slot = slot + 1'b1;

    if (w.mode_active) begin
      lim = alarm_lim;
      if (lim < p / int'(AlarmScale)) alarm_on = 1'b1;
      if (w.insp_time_count >= insp_limit) alarm_on = 1'b0;
      if (w.trigger_view && w.inspiration_flow) alarm_on = 1'b0;
      if (alarm_on) hold_cnt = hold_cnt + 1'b1;
      else hold_cnt = '0;
      if (hold_cnt > HoldMax) begin
        hold_cnt = '0;
        alarm_on = 1'b0;
      end
    end

    // first strictly largest positive slot, then the best of the others
    peak      = 0;
    peak_slot = 0;
    second    = 0;
    for (int i = 0; i < WINDOW; i++) begin
      if (peak < pres_ring[i]) begin
        peak      = pres_ring[i];
        peak_slot = i;
      end
    end
    for (int i = 0; i < WINDOW; i++)
      if (second < pres_ring[i] && i != peak_slot) second = pres_ring[i];

    r.raw_average      = 16'(rsum / longint'(WINDOW));
    r.pressure_now     = 16'(p);
    r.pressure_average = 16'(sat16(psum));
    r.second_peak      = 15'(second);
    r.high_alarm       = alarm_on;
    r.cal_error        = err;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_pt    = '0;
      thirty_pt  = '0;
      sixty_pt   = '0;
      insp_limit = '0;
      alarm_lim  = '0;
      for (int i = 0; i < WINDOW; i++) begin
        raw_ring[i]  = '0;
        pres_ring[i] = 0;
      end
      slot         = '0;
      alarm_on     = 1'b0;
      hold_cnt     = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      alarms_o     = 0;
      cal_errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ZERO_POINT:      zero_pt    = cfg_data_i;
          CFG_THIRTY_POINT:    thirty_pt  = cfg_data_i;
          CFG_SIXTY_POINT:     sixty_pt   = cfg_data_i;
          CFG_ALARM_LIMIT:     alarm_lim  = cfg_data_i[11:0];
          CFG_INSP_TIME_LIMIT: insp_limit = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) expected_q.push_back(condition_word(in_data_i));

      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word %0d with no input word outstanding",
                                    results_o));
        end else begin
          want = expected_q.pop_front();
          if (want.high_alarm) alarms_o++;
          if (want.cal_error) cal_errors_o++;
          if (out_data_i.raw_average !== want.raw_average)
            report_mismatch($sformatf("word %0d raw_average %0d, want %0d", results_o,
                                      out_data_i.raw_average, want.raw_average));
          if (out_data_i.pressure_now !== want.pressure_now)
            report_mismatch($sformatf("word %0d pressure_now %0d, want %0d", results_o,
                                      out_data_i.pressure_now, want.pressure_now));
          if (out_data_i.pressure_average !== want.pressure_average)
            report_mismatch($sformatf("word %0d pressure_average %0d, want %0d", results_o,
                                      out_data_i.pressure_average, want.pressure_average));
          if (out_data_i.second_peak !== want.second_peak)
            report_mismatch($sformatf("word %0d second_peak %0d, want %0d", results_o,
                                      out_data_i.second_peak, want.second_peak));
          if (out_data_i.high_alarm !== want.high_alarm)
            report_mismatch($sformatf("word %0d high_alarm %b, want %b", results_o,
                                      out_data_i.high_alarm, want.high_alarm));
          if (out_data_i.cal_error !== want.cal_error)
            report_mismatch($sformatf("word %0d cal_error %b, want %b", results_o,
                                      out_data_i.cal_error, want.cal_error));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// tb_top
// Stimulus and verdict for the pressure sensor conditioner: directed words
// at the calibration points, saturation, short and inverted spans and the
// alarm clears, then random words in bursts under random register settings,
// with random idling on both channels. Checking lives in psc_checker.
// ============================================================================
module tb_top import psc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound on the run of ~470 words
  localparam int CycleLimit = 300000;
  // tail after the last result, longer than one word's latency
  localparam int TailCycles = 60;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  psc_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  psc_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int fail_count, pending, results, alarms, cal_errors;
  int cycles   = 0;
  int settings = 0;

  // per-cycle idle odds, in percent, for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // current calibration, used to aim samples near the break points
  int cur_zero, cur_thirty, cur_sixty, cur_itl;

  pressure_sensor_conditioner dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  psc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .alarms_o     (alarms),
    .cal_errors_o (cal_errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d result words still outstanding",
               cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: ready drops at random, per cycle
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic psc_in_t word_of(input logic [15:0] s, input logic mode, tview,
                                      input logic iflow, input logic [15:0] itime);
    psc_in_t w;
    w.sample           = s;
    w.mode_active      = mode;
    w.trigger_view     = tview;
    w.inspiration_flow = iflow;
    w.insp_time_count  = itime;
    return w;
  endfunction

  // samples near the break points, above the thirty point, at the ends of the range, or anywhere
  function automatic logic [15:0] pick_sample();
    int v;
    case ($urandom_range(5))
      0: v = $urandom_range(65535);
      1: v = cur_zero + int'($urandom_range(128)) - 64;
      2: v = cur_thirty + int'($urandom_range(128)) - 64;
      3: v = cur_sixty + int'($urandom_range(128)) - 64;
      4: v = $urandom_range(65535, cur_thirty);
      default: v = $urandom_range(1) ? $urandom_range(255) : 65535 - $urandom_range(255);
    endcase
    return clamp16(v);
  endfunction

  // segment span: mostly valid, sometimes short or inverted
  function automatic int span_pick();
    int s;
    case ($urandom_range(9))
      0:       s = $urandom_range(29);
      1:       s = -int'($urandom_range(5000, 1));
      2, 3:    s = $urandom_range(300, 30);
      default: s = $urandom_range(12000, 30);
    endcase
    return s;
  endfunction

  // All five registers back to back; we stays high across the burst.
  task automatic write_cal(input logic [15:0] zero, thirty, sixty, lim, itl);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ZERO_POINT;
    cfg_data <= zero;
    @(negedge clk);
    cfg_idx  <= CFG_THIRTY_POINT;
    cfg_data <= thirty;
    @(negedge clk);
    cfg_idx  <= CFG_SIXTY_POINT;
    cfg_data <= sixty;
    @(negedge clk);
    cfg_idx  <= CFG_ALARM_LIMIT;
    cfg_data <= lim;
    @(negedge clk);
    cfg_idx  <= CFG_INSP_TIME_LIMIT;
    cfg_data <= itl;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_zero   = int'(zero);
    cur_thirty = int'(thirty);
    cur_sixty  = int'(sixty);
    cur_itl    = int'(itl);
    settings++;
  endtask

  // Offer one word. Idle cycles come first; valid then holds until the
  // handshake, and the task returns on the following falling edge.
  task automatic send_word(input psc_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result; every word gives
  // exactly one, so the block is idle once the count reaches zero.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Random words in bursts. Pressure runs keep the alarm logic enabled with
  // samples from pick_sample and the clear conditions mostly off, so the hold
  // counter gets to run out; noise bursts are fully random words.
  task automatic run_random(input int count);
    psc_in_t w;
    int      left, len;
    bit      pressure_run;
    left = count;
    while (left > 0) begin
      pressure_run = ($urandom_range(9) < 6);
      len = pressure_run ? $urandom_range(24, 12) : $urandom_range(8, 1);
      if (len > left) len = left;
      repeat (len) begin
        w.sample           = 16'($urandom);
        w.mode_active      = 1'($urandom);
        w.trigger_view     = 1'($urandom);
        w.inspiration_flow = 1'($urandom);
        w.insp_time_count  = 16'($urandom);
        if (pressure_run) begin
          w.sample      = pick_sample();
          w.mode_active = 1'b1;
          // one word in ten is left free to break the run
          if ($urandom_range(9) != 0) begin
            if (w.trigger_view) w.inspiration_flow = 1'b0;
            if (cur_itl > 0) w.insp_time_count = 16'($urandom_range(cur_itl - 1));
          end
        end
        send_word(w);
        left--;
      end
    end
  endtask

  initial begin
    int zero, thirty, sixty, lim, itl;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 59;

    // --- directed ---------------------------------------------------------
    // Typical curve, 300 counts per cmH2O on both segments, alarm above
    // 20 cmH2O, alarm cleared from 1000 inspiration ticks.
    write_cal(16'd1000, 16'd10000, 16'd19000, 16'd20, 16'd1000);
    send_word(word_of(16'd0,     1'b0, 1'b0, 1'b0, 16'd0));     // extrapolated below zero
    send_word(word_of(16'hffff,  1'b1, 1'b0, 1'b0, 16'd0));     // top of range, alarm set
    send_word(word_of(16'd999,   1'b1, 1'b0, 1'b0, 16'd999));   // just below zero point
    send_word(word_of(16'd1000,  1'b1, 1'b1, 1'b0, 16'd500));   // on the zero point
    send_word(word_of(16'd9999,  1'b1, 1'b0, 1'b1, 16'd500));   // just below thirty point
    send_word(word_of(16'd10000, 1'b1, 1'b1, 1'b1, 16'd500));   // trigger view inspiration
    send_word(word_of(16'd19000, 1'b1, 1'b0, 1'b0, 16'd999));   // sixty point, alarm again
    send_word(word_of(16'd19000, 1'b1, 1'b0, 1'b0, 16'd1000));  // inspiration time runs out
    send_word(word_of(16'd30000, 1'b0, 1'b1, 1'b1, 16'hffff));  // alarm logic disabled
    send_word(word_of(16'd1,     1'b1, 1'b0, 1'b0, 16'hffff));
    drain();

    // One count per cmH2O: both ends saturate.
    write_cal(16'd30000, 16'd30030, 16'd30060, 16'd0, 16'hffff);
    send_word(word_of(16'hffff,  1'b1, 1'b0, 1'b0, 16'd65534));
    send_word(word_of(16'd0,     1'b1, 1'b0, 1'b0, 16'd0));
    send_word(word_of(16'd30015, 1'b1, 1'b0, 1'b0, 16'd12345));
    send_word(word_of(16'd30045, 1'b0, 1'b0, 1'b0, 16'd0));
    drain();

    // Inverted lower segment and a 29-count upper segment: errors both ways.
    write_cal(16'd40000, 16'd20000, 16'd20029, 16'd4095, 16'd0);
    send_word(word_of(16'd10000, 1'b1, 1'b0, 1'b0, 16'd0));
    send_word(word_of(16'd25000, 1'b1, 1'b0, 1'b0, 16'd0));
    send_word(word_of(16'd20000, 1'b1, 1'b0, 1'b1, 16'd7));
    drain();

    // All points at full scale, then all at zero.
    write_cal(16'hffff, 16'hffff, 16'hffff, 16'd4095, 16'hffff);
    send_word(word_of(16'hffff,  1'b1, 1'b0, 1'b0, 16'd0));
    send_word(word_of(16'd0,     1'b1, 1'b1, 1'b0, 16'hffff));
    drain();
    write_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(word_of(16'd0,     1'b1, 1'b0, 1'b0, 16'd0));
    send_word(word_of(16'd12345, 1'b1, 1'b0, 1'b1, 16'd1));
    drain();

    // --- random -----------------------------------------------------------
    // Three idling regimes, three register settings in each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        zero   = $urandom_range(30000);
        thirty = zero + span_pick();
        sixty  = thirty + span_pick();
        lim    = $urandom_range(1) ? $urandom_range(150) : $urandom_range(4095);
        case ($urandom_range(19))
          0, 1, 2: itl = 0;
          3, 4, 5: itl = 65535;
          default: itl = $urandom_range(65535, 1000);
        endcase
        write_cal(clamp16(zero), clamp16(thirty), clamp16(sixty), lim[15:0], itl[15:0]);
        run_random(50);
        drain();
      end
    end

    // anything stray after the last expected word is flagged by the checker
    repeat (TailCycles) @(negedge clk);

    $display("Checked %0d result words across %0d register settings and three idling regimes.",
             results, settings);
    $display("Alarm was up in %0d of them, calibration error in %0d; %0d mismatches.",
             alarms, cal_errors, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_div.sv
rtl/pressure_sensor_conditioner.sv
tb/psc_checker.sv
tb/tb_top.sv
